// ----- design/rhcc_pkg.sv -----
`timescale 1ns / 1ps

package rhcc_pkg;

    localparam int BYTE_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RECORD_MAGIC   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_VERSION    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_OLD     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_CURRENT = 3'd3;

    localparam logic [BYTE_W-1:0] MAGIC_RESET   = 8'hbe;
    localparam logic [BYTE_W-1:0] VERSION_RESET = 8'd1;

    // record status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM     = 3'd4;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic                has_byte;
        logic [BYTE_W-1:0]   payload_byte;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   record_version;
    } t_out_item;

endpackage

// ----- design/rhcc_sum.sv -----
`timescale 1ns / 1ps

module rhcc_sum (
    input  logic [7:0]  i_low,
    input  logic [15:0] i_high,
    input  logic [7:0]  i_byte,
    output logic [7:0]  o_low,
    output logic [15:0] o_high
);

    logic [8:0]  low_sum;
    logic [8:0]  low_red;
    logic [16:0] mix;
    logic [9:0]  fold1;
    logic [8:0]  fold2;
    logic [8:0]  mix_red;

    // low sum stays below 510, so one conditional subtract is enough
    assign low_sum = {1'b0, i_low} + {1'b0, i_byte};
    assign low_red = (low_sum >= 9'd255) ? (low_sum - 9'd255) : low_sum;
    assign o_low   = low_red[7:0];

    // mod 255 by folding bytes, since 256 is 1 mod 255
    assign mix     = {9'd0, o_low} + {1'b0, i_high};
    assign fold1   = {2'd0, mix[7:0]} + {2'd0, mix[15:8]} + {9'd0, mix[16]};
    assign fold2   = {1'b0, fold1[7:0]} + {7'd0, fold1[9:8]};
    assign mix_red = (fold2 >= 9'd255) ? (fold2 - 9'd255) : fold2;

    assign o_high = i_high + {8'd0, mix_red[7:0]};

endmodule

// ----- design/rhcc_skid.sv -----
`timescale 1ns / 1ps

module rhcc_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  rhcc_pkg::t_out_item i_res_item,
    output logic                o_ready,
    output logic                o_valid,
    output rhcc_pkg::t_out_item o_item,
    input  logic                i_stall
);

    logic                r_main_valid;
    logic                r_skid_valid;
    rhcc_pkg::t_out_item r_main;
    rhcc_pkg::t_out_item r_skid;
    logic                n_main_valid;
    logic                n_skid_valid;
    rhcc_pkg::t_out_item n_main;
    rhcc_pkg::t_out_item n_skid;
    logic                take;

    assign take    = r_main_valid && !i_stall;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_item  = r_main;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            // no new result arrives while the skid entry is full
            if (take) begin
                n_main       = r_skid;
                n_main_valid = 1'b1;
                n_skid_valid = 1'b0;
            end
        end else if (take || !r_main_valid) begin
            n_main_valid = i_res_valid;
            n_main       = i_res_item;
        end else if (i_res_valid) begin
            n_skid       = i_res_item;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

// ----- design/record_header_checksum_checker_core.sv -----
`timescale 1ns / 1ps

// Record stream checker. Each input item is one stream byte (op = byte) or an
// end-of-stream mark. A record is magic, version, checksum low, checksum high,
// then a payload whose length comes from length_old (version 0) or
// length_current (version max_version). Payload bytes come out one result
// each; the last result of a record has done_res set and carries the status.
// Header bytes give no result unless they end the record (empty payload or error).
// An accepted item waits in the input register; its result is computed from
// there and held in the result register, which offers it on the output channel.
// One item per cycle is taken while the output buffer has room; the per-byte
// checksum step is a short mod-255 fold between the input and result registers.
// Input stall rises only when the input register is full and the two-entry
// output buffer (result register plus skid entry) cannot take a result, so a
// stalled receiver holds the result steady and backs up the input side.
// Synchronous reset puts the checker in idle awaiting a magic byte, clears
// the sums and restores the register defaults (magic 0xbe, max version 1,
// both lengths 0). Registers are to be written through the plain write port
// only while the block is idle, by the user; the block does not enforce it.

module record_header_checksum_checker_core #(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rhcc_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rhcc_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_we,
    input  logic [rhcc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [rhcc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_VER  = 3'd1;
    localparam logic [2:0] PH_CKLO = 3'd2;
    localparam logic [2:0] PH_CKHI = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;

    localparam int LEN_EXT_W = LENGTH_WIDTH + rhcc_pkg::CFG_DATA_W;

    // configuration
    logic [7:0]  r_magic;
    logic [7:0]  r_max_version;
    logic [15:0] r_length_old;
    logic [15:0] r_length_current;

    // input register
    logic                r_in_valid;
    rhcc_pkg::t_in_item  r_in_item;

    // record state
    logic [2:0]              r_phase;
    logic [7:0]              r_version;
    logic [15:0]             r_checksum;
    logic [7:0]              r_low;
    logic [15:0]             r_high;
    logic [LENGTH_WIDTH-1:0] r_remaining;

    logic [2:0]              n_phase;
    logic [7:0]              n_version;
    logic [15:0]             n_checksum;
    logic [7:0]              n_low;
    logic [15:0]             n_high;
    logic [LENGTH_WIDTH-1:0] n_remaining;

    logic                res_valid;
    rhcc_pkg::t_out_item res_item;
    logic                out_ready;
    logic                fire;
    logic                in_accept;

    logic [7:0]              b;
    logic [7:0]              sum_low;
    logic [15:0]             sum_high;
    logic [LEN_EXT_W-1:0]    len_old_ext;
    logic [LEN_EXT_W-1:0]    len_cur_ext;
    logic [LENGTH_WIDTH-1:0] rem_dec;

    assign fire       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign b          = r_in_item.byte_value;

    assign len_old_ext = {{LENGTH_WIDTH{1'b0}}, r_length_old};
    assign len_cur_ext = {{LENGTH_WIDTH{1'b0}}, r_length_current};
    assign rem_dec     = r_remaining - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

    rhcc_sum u_sum (
        .i_low  (r_low),
        .i_high (r_high),
        .i_byte (b),
        .o_low  (sum_low),
        .o_high (sum_high)
    );

    always_comb begin
        n_phase     = r_phase;
        n_version   = r_version;
        n_checksum  = r_checksum;
        n_low       = r_low;
        n_high      = r_high;
        n_remaining = r_remaining;
        res_valid   = 1'b0;
        res_item    = '0;

        if (r_in_item.op == rhcc_pkg::OP_END) begin
            // end of stream cuts the record short, or reports an empty stream
            if (r_phase == PH_IDLE || r_phase > PH_DATA) begin
                n_version = 8'd0;
            end
            res_valid               = 1'b1;
            res_item.done_res       = 1'b1;
            res_item.status         = rhcc_pkg::ST_SHORT;
            res_item.record_version = n_version;
            n_phase                 = PH_IDLE;
        end else begin
            unique case (r_phase)
                PH_VER: begin
                    n_version = b;
                    if (b > r_max_version) begin
                        res_valid = 1'b1;
                    end else if (b == 8'd0) begin
                        n_remaining = len_old_ext[LENGTH_WIDTH-1:0];
                        n_phase     = PH_CKLO;
                    end else if (b == r_max_version) begin
                        n_remaining = len_cur_ext[LENGTH_WIDTH-1:0];
                        n_phase     = PH_CKLO;
                    end else begin
                        res_valid = 1'b1;
                    end
                    if (res_valid) begin
                        res_item.done_res       = 1'b1;
                        res_item.status         = rhcc_pkg::ST_BAD_VERSION;
                        res_item.record_version = b;
                        n_phase                 = PH_IDLE;
                    end
                end
                PH_CKLO: begin
                    n_checksum = {8'd0, b};
                    n_phase    = PH_CKHI;
                end
                PH_CKHI: begin
                    n_checksum = {b, r_checksum[7:0]};
                    if (r_remaining == '0) begin
                        // empty payload: sums are still zero
                        res_valid               = 1'b1;
                        res_item.done_res       = 1'b1;
                        res_item.status         = ({r_high[7:0], r_low} == n_checksum) ?
                                                  rhcc_pkg::ST_OK : rhcc_pkg::ST_BAD_SUM;
                        res_item.record_version = r_version;
                        n_phase                 = PH_IDLE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_low                 = sum_low;
                    n_high                = sum_high;
                    n_remaining           = rem_dec;
                    res_valid             = 1'b1;
                    res_item.has_byte     = 1'b1;
                    res_item.payload_byte = b;
                    if (rem_dec == '0) begin
                        res_item.done_res       = 1'b1;
                        res_item.status         = ({sum_high[7:0], sum_low} == r_checksum) ?
                                                  rhcc_pkg::ST_OK : rhcc_pkg::ST_BAD_SUM;
                        res_item.record_version = r_version;
                        n_phase                 = PH_IDLE;
                    end
                end
                default: begin
                    // idle: a new record starts with a fresh state
                    n_version   = 8'd0;
                    n_checksum  = 16'd0;
                    n_low       = 8'd0;
                    n_high      = 16'd0;
                    n_remaining = '0;
                    if (b != r_magic) begin
                        res_valid               = 1'b1;
                        res_item.done_res       = 1'b1;
                        res_item.status         = rhcc_pkg::ST_BAD_MAGIC;
                        res_item.record_version = 8'd0;
                        n_phase                 = PH_IDLE;
                    end else begin
                        n_phase = PH_VER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_phase          <= PH_IDLE;
            r_version        <= 8'd0;
            r_checksum       <= 16'd0;
            r_low            <= 8'd0;
            r_high           <= 16'd0;
            r_remaining      <= '0;
            r_magic          <= rhcc_pkg::MAGIC_RESET;
            r_max_version    <= rhcc_pkg::VERSION_RESET;
            r_length_old     <= 16'd0;
            r_length_current <= 16'd0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_phase     <= n_phase;
                r_version   <= n_version;
                r_checksum  <= n_checksum;
                r_low       <= n_low;
                r_high      <= n_high;
                r_remaining <= n_remaining;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rhcc_pkg::CFG_RECORD_MAGIC:   r_magic          <= i_cfg_data[7:0];
                    rhcc_pkg::CFG_MAX_VERSION:    r_max_version    <= i_cfg_data[7:0];
                    rhcc_pkg::CFG_LENGTH_OLD:     r_length_old     <= i_cfg_data;
                    rhcc_pkg::CFG_LENGTH_CURRENT: r_length_current <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
        if (in_accept) begin
            r_in_item <= i_in_item;
        end
    end

    rhcc_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (fire && res_valid),
        .i_res_item  (res_item),
        .o_ready     (out_ready),
        .o_valid     (o_out_valid),
        .o_item      (o_out_item),
        .i_stall     (i_out_stall)
    );

endmodule
